>>> src/ipv4hc_pkg.sv
package ipv4hc_pkg;

  // Verdict codes
  localparam logic [2:0] VERDICT_ACCEPT       = 3'd0;
  localparam logic [2:0] VERDICT_NOT_IPV4     = 3'd1;
  localparam logic [2:0] VERDICT_BAD_SIZE     = 3'd2;
  localparam logic [2:0] VERDICT_BAD_CHECKSUM = 3'd3;
  localparam logic [2:0] VERDICT_NOT_FOR_US   = 3'd4;

  // Configuration register indexes
  localparam logic REG_LOCAL_ADDRESS = 1'b0;
  localparam logic REG_SUBNET_MASK   = 1'b1;

  // Header word positions (16-bit words from the start of the header)
  localparam logic [4:0] WORD_TOTAL_LENGTH = 5'd1;
  localparam logic [4:0] WORD_TTL_PROTOCOL = 5'd4;
  localparam logic [4:0] WORD_CHECKSUM     = 5'd5;
  localparam logic [4:0] WORD_DEST_HIGH    = 5'd8;
  localparam logic [4:0] WORD_DEST_LOW     = 5'd9;

  localparam logic [3:0]  IP_VERSION_4    = 4'd4;
  localparam logic [3:0]  MIN_IHL         = 4'd5;
  localparam logic [15:0] MIN_HDR_BYTES   = 16'd20;
  localparam logic [15:0] SUM_ALL_ONES    = 16'hFFFF;
  localparam logic [31:0] LIMITED_BCAST   = 32'hFFFF_FFFF;

  // One input item
  typedef struct packed {
    logic        start_of_packet;
    logic [15:0] header_word;
    logic [15:0] buffer_length;
  } item_t;

  // One result item
  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  protocol_number;
    logic [15:0] packet_length;
  } result_t;

endpackage

>>> src/ipv4hc_in_stage.sv
module ipv4hc_in_stage
  import ipv4hc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  // Take a new item when empty or when the held one moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

>>> src/ipv4hc_parser.sv
module ipv4hc_parser
  import ipv4hc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        step,
  input  item_t       item,
  output logic        res_valid,
  output result_t     res
);

  logic [31:0] local_address;
  logic [31:0] subnet_mask;

  logic [4:0]  word_index, word_index_next;
  logic [4:0]  words_expected, words_expected_next;
  logic [15:0] ones_sum, ones_sum_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] buffer_length, buffer_length_next;
  logic [7:0]  protocol, protocol_next;
  logic        checksum_present, checksum_present_next;
  logic [31:0] destination, destination_next;
  logic [2:0]  pending_error, pending_error_next;
  logic        active, active_next;

  logic [3:0]  version;
  logic [3:0]  ihl;
  logic [4:0]  index_inc;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

  function automatic logic dest_matches(input logic [31:0] d, input logic [31:0] addr,
                                        input logic [31:0] mask);
    logic [31:0] host;
    host = ~mask;
    return (d == LIMITED_BCAST)
        || (((d & host) == host) && ((d & mask) == (addr & mask)))
        || (d == addr);
  endfunction

  // Hold the interface address and mask
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
      subnet_mask   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOCAL_ADDRESS: local_address <= cfg_data;
        REG_SUBNET_MASK:   subnet_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign version   = item.header_word[15:12];
  assign ihl       = item.header_word[11:8];
  assign index_inc = word_index + 5'd1;

  // Advance header state by one word; give a verdict on the first or last word
  always_comb begin
    word_index_next       = word_index;
    words_expected_next   = words_expected;
    ones_sum_next         = ones_sum;
    total_length_next     = total_length;
    buffer_length_next    = buffer_length;
    protocol_next         = protocol;
    checksum_present_next = checksum_present;
    destination_next      = destination;
    pending_error_next    = pending_error;
    active_next           = active;
    res_valid             = 1'b0;
    res                   = '0;

    if (step) begin
      if (item.start_of_packet) begin
        word_index_next       = '0;
        words_expected_next   = '0;
        ones_sum_next         = '0;
        total_length_next     = '0;
        protocol_next         = '0;
        checksum_present_next = 1'b0;
        destination_next      = '0;
        pending_error_next    = VERDICT_ACCEPT;
        active_next           = 1'b0;
        buffer_length_next    = item.buffer_length;
        if (version != IP_VERSION_4) begin
          res_valid   = 1'b1;
          res.verdict = VERDICT_NOT_IPV4;
        end else if (ihl < MIN_IHL) begin
          res_valid   = 1'b1;
          res.verdict = VERDICT_BAD_SIZE;
        end else begin
          active_next         = 1'b1;
          words_expected_next = {ihl, 1'b0};
          ones_sum_next       = item.header_word;
          word_index_next     = 5'd1;
        end
      end else if (active) begin
        ones_sum_next = oc_add(ones_sum, item.header_word);
        case (word_index)
          WORD_TOTAL_LENGTH: begin
            total_length_next = item.header_word;
            if (((item.header_word < MIN_HDR_BYTES) || (buffer_length < item.header_word))
                && (pending_error == VERDICT_ACCEPT)) begin
              pending_error_next = VERDICT_BAD_SIZE;
            end
          end
          WORD_TTL_PROTOCOL: protocol_next = item.header_word[7:0];
          WORD_CHECKSUM:     checksum_present_next = (item.header_word != 16'd0);
          WORD_DEST_HIGH:    destination_next = {item.header_word, destination[15:0]};
          WORD_DEST_LOW:     destination_next = {destination[31:16], item.header_word};
          default: ;
        endcase
        word_index_next = index_inc;
        if (index_inc == words_expected) begin
          active_next         = 1'b0;
          res_valid           = 1'b1;
          res.protocol_number = protocol_next;
          res.packet_length   = total_length_next;
          if (pending_error_next != VERDICT_ACCEPT) begin
            res.verdict = pending_error_next;
          end else if (checksum_present_next && (ones_sum_next != SUM_ALL_ONES)) begin
            res.verdict = VERDICT_BAD_CHECKSUM;
          end else if (!dest_matches(destination_next, local_address, subnet_mask)) begin
            res.verdict = VERDICT_NOT_FOR_US;
          end else begin
            res.verdict = VERDICT_ACCEPT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index       <= '0;
      words_expected   <= '0;
      ones_sum         <= '0;
      total_length     <= '0;
      buffer_length    <= '0;
      protocol         <= '0;
      checksum_present <= 1'b0;
      destination      <= '0;
      pending_error    <= VERDICT_ACCEPT;
      active           <= 1'b0;
    end else begin
      word_index       <= word_index_next;
      words_expected   <= words_expected_next;
      ones_sum         <= ones_sum_next;
      total_length     <= total_length_next;
      buffer_length    <= buffer_length_next;
      protocol         <= protocol_next;
      checksum_present <= checksum_present_next;
      destination      <= destination_next;
      pending_error    <= pending_error_next;
      active           <= active_next;
    end
  end

endmodule

>>> src/ipv4hc_out_stage.sv
module ipv4hc_out_stage
  import ipv4hc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  // Free when empty or when the waiting item is taken this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_res <= load_res;
    end
  end

endmodule

>>> src/ipv4_header_checker.sv
// IPv4 header checker: takes a header as 16-bit big-endian words, one item per
// cycle, the first word flagged in s_tuser together with the buffer length, and
// gives one verdict per header (accept, not IPv4, bad size, bad checksum, not
// for us) with the protocol and total length. A bad version or short header
// length is reported on the first word; otherwise the verdict follows the last
// header word. One item is accepted every cycle while m_tready keeps up; the
// item sits in an input register, and its result is then loaded into the
// result register that drives m_tvalid, once that register is free. s_tready
// follows m_tready through those two stages. Write the address and mask only
// while no header is in flight.
module ipv4_header_checker
  import ipv4hc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,     // 0 local_address, 1 subnet_mask
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // [15:0] header_word, [31:16] buffer_length
  input  logic        s_tuser,       // [0] start_of_packet
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // [2:0] verdict, [10:3] protocol_number,
                                     // [26:11] packet_length, [31:27] zero
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    can_load;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.start_of_packet = s_tuser;
  assign in_item.header_word     = s_tdata[15:0];
  assign in_item.buffer_length   = s_tdata[31:16];

  // Move the held item through the parser when the result register can take it
  assign advance = held_valid && can_load;

  ipv4hc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ipv4hc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ipv4hc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {5'd0, out_res.packet_length, out_res.protocol_number, out_res.verdict};

endmodule
